>>> hdl/dn_to_toa_reflectance_calibrator_macros.svh
// Assertion macros for the checker file of the calibrator.
`ifndef DN_TO_TOA_REFLECTANCE_CALIBRATOR_MACROS_SVH
`define DN_TO_TOA_REFLECTANCE_CALIBRATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("calibrator check failed");

// The consequent must hold in the cycle after the antecedent.
`define DTRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("calibrator check failed");

`endif

>>> hdl/dtrc_pkg.sv
package dtrc_pkg;

	localparam int COUNT_BITS_DEFAULT = 32;

	localparam int SHOW_BITS = 32;
	localparam int IN_DATA_BITS = 32;
	localparam int IN_USER_BITS = 1;
	localparam int OUT_DATA_BITS = 144;
	localparam int OUT_USER_BITS = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_INDEX_BITS = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_INPUT_FILL = 3'd0,
		REG_QA_FILL    = 3'd1,
		REG_SATURATION = 3'd2,
		REG_SLOPE      = 3'd3,
		REG_OFFSET     = 3'd4,
		REG_VALID_LOW  = 3'd5,
		REG_VALID_HIGH = 3'd6,
		REG_SPECIAL    = 3'd7
	} cfg_reg_t;

	localparam logic [15:0] INPUT_FILL_RESET = 16'd0;
	localparam logic [15:0] QA_FILL_RESET = 16'd1;
	localparam logic [15:0] SATURATION_RESET = 16'd255;
	localparam logic signed [31:0] SLOPE_RESET = 32'sd65536;
	localparam logic signed [31:0] OFFSET_RESET = 32'sd0;
	localparam logic signed [15:0] VALID_LOW_RESET = -16'sd2000;
	localparam logic signed [15:0] VALID_HIGH_RESET = 16'sd16000;
	localparam logic [31:0] SPECIAL_RESET = 32'd1310710513;

	// Output stream bit positions, shared with the port checker.
	localparam int USER_FILL = 0;
	localparam int USER_SAT = 1;
	localparam int USER_STATS = 2;

endpackage

>>> hdl/dn_to_toa_reflectance_calibrator.sv
// A pixel accepted into the input register passes the product register and the result register to the output.
// Throughput: one pixel per cycle; a stalled output freezes the whole three-stage pipeline.
// The pipeline is an input register, a product register after the 32x17 multiplier, and the
// result register after rounding, clamping and the statistics update.
// Reset (arst_n low) clears the valid bits, counters and configuration to their defaults.
module dn_to_toa_reflectance_calibrator #(
	parameter int COUNT_BITS = dtrc_pkg::COUNT_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// sample [15:0], qa_word [31:16]
	input  logic [dtrc_pkg::IN_DATA_BITS-1:0]   s_tdata,
	// band_start [0]
	input  logic [dtrc_pkg::IN_USER_BITS-1:0]   s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// refl_value [15:0], fill_total [47:16], valid_total [79:48], min_dn [95:80],
	// max_dn [111:96], min_out [127:112], max_out [143:128]
	output logic [dtrc_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	// is_fill [0], is_saturated [1], stats_ready [2]
	output logic [dtrc_pkg::OUT_USER_BITS-1:0]  m_tuser,
	input  logic                                cfg_we,
	input  logic [dtrc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [dtrc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int ShowW = (COUNT_BITS > dtrc_pkg::SHOW_BITS) ? COUNT_BITS : dtrc_pkg::SHOW_BITS;

	logic [15:0] input_fill_q;
	logic [15:0] qa_fill_q;
	logic [15:0] saturation_q;
	logic signed [31:0] slope_q;
	logic signed [31:0] offset_q;
	logic signed [15:0] valid_low_q;
	logic signed [15:0] valid_high_q;
	logic [31:0] special_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_fill_q <= dtrc_pkg::INPUT_FILL_RESET;
			qa_fill_q <= dtrc_pkg::QA_FILL_RESET;
			saturation_q <= dtrc_pkg::SATURATION_RESET;
			slope_q <= dtrc_pkg::SLOPE_RESET;
			offset_q <= dtrc_pkg::OFFSET_RESET;
			valid_low_q <= dtrc_pkg::VALID_LOW_RESET;
			valid_high_q <= dtrc_pkg::VALID_HIGH_RESET;
			special_q <= dtrc_pkg::SPECIAL_RESET;
		end else if (cfg_we) begin
			unique case (dtrc_pkg::cfg_reg_t'(cfg_index))
				dtrc_pkg::REG_INPUT_FILL: input_fill_q <= cfg_data[15:0];
				dtrc_pkg::REG_QA_FILL:    qa_fill_q <= cfg_data[15:0];
				dtrc_pkg::REG_SATURATION: saturation_q <= cfg_data[15:0];
				dtrc_pkg::REG_SLOPE:      slope_q <= $signed(cfg_data);
				dtrc_pkg::REG_OFFSET:     offset_q <= $signed(cfg_data);
				dtrc_pkg::REG_VALID_LOW:  valid_low_q <= $signed(cfg_data[15:0]);
				dtrc_pkg::REG_VALID_HIGH: valid_high_q <= $signed(cfg_data[15:0]);
				dtrc_pkg::REG_SPECIAL:    special_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic adv;
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	// Stage 1: input register.
	logic        v_s1;
	logic [15:0] dn_s1;
	logic [15:0] qa_s1;
	logic        start_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s_tvalid) begin
			dn_s1 <= s_tdata[15:0];
			qa_s1 <= s_tdata[31:16];
			start_s1 <= s_tuser[0];
		end
	end

	logic signed [48:0] prod_s1;
	logic signed [49:0] acc_s1;
	logic               fill_s1;
	logic               sat_s1;

	assign prod_s1 = slope_q * $signed({1'b0, dn_s1});
	assign acc_s1 = 50'(prod_s1) + 50'(offset_q);
	assign fill_s1 = (dn_s1 == input_fill_q) || (qa_s1 == qa_fill_q);
	assign sat_s1 = !fill_s1 && (dn_s1 == saturation_q);

	// Stage 2: product register.
	logic               v_s2;
	logic signed [49:0] acc_s2;
	logic               fill_s2;
	logic               sat_s2;
	logic [15:0]        dn_s2;
	logic               start_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			acc_s2 <= acc_s1;
			fill_s2 <= fill_s1;
			sat_s2 <= sat_s1;
			dn_s2 <= dn_s1;
			start_s2 <= start_s1;
		end
	end

	logic signed [49:0] rnd_s2;
	logic signed [33:0] whole_s2;
	logic signed [15:0] clamp_s2;
	logic signed [15:0] value_s2;

	assign rnd_s2 = acc_s2 + 50'sd32768;
	assign whole_s2 = 34'(rnd_s2 >>> 16);

	always_comb begin
		if (whole_s2 < 34'(valid_low_q)) begin
			clamp_s2 = valid_low_q;
		end else if (whole_s2 > 34'(valid_high_q)) begin
			clamp_s2 = valid_high_q;
		end else begin
			clamp_s2 = whole_s2[15:0];
		end
		if (fill_s2) begin
			value_s2 = $signed(special_q[15:0]);
		end else if (sat_s2) begin
			value_s2 = $signed(special_q[31:16]);
		end else begin
			value_s2 = clamp_s2;
		end
	end

	// Running band statistics.
	logic [COUNT_BITS-1:0] fill_cnt_q;
	logic [COUNT_BITS-1:0] valid_cnt_q;
	logic                  seen_q;
	logic [15:0]           dn_lo_q;
	logic [15:0]           dn_hi_q;
	logic signed [15:0]    out_lo_q;
	logic signed [15:0]    out_hi_q;

	logic [COUNT_BITS-1:0] fill_cnt_d;
	logic [COUNT_BITS-1:0] valid_cnt_d;
	logic                  seen_d;
	logic [15:0]           dn_lo_d;
	logic [15:0]           dn_hi_d;
	logic signed [15:0]    out_lo_d;
	logic signed [15:0]    out_hi_d;
	logic                  conv_s2;

	assign conv_s2 = !fill_s2 && !sat_s2;

	always_comb begin
		fill_cnt_d = start_s2 ? '0 : fill_cnt_q;
		valid_cnt_d = start_s2 ? '0 : valid_cnt_q;
		seen_d = start_s2 ? 1'b0 : seen_q;
		dn_lo_d = dn_lo_q;
		dn_hi_d = dn_hi_q;
		out_lo_d = out_lo_q;
		out_hi_d = out_hi_q;
		if (fill_s2 && (fill_cnt_d != '1)) begin
			fill_cnt_d = fill_cnt_d + COUNT_BITS'(1);
		end
		if (conv_s2) begin
			if (valid_cnt_d != '1) begin
				valid_cnt_d = valid_cnt_d + COUNT_BITS'(1);
			end
			if (!seen_d) begin
				dn_lo_d = dn_s2;
				dn_hi_d = dn_s2;
				out_lo_d = clamp_s2;
				out_hi_d = clamp_s2;
			end else begin
				if (dn_s2 < dn_lo_q) dn_lo_d = dn_s2;
				if (dn_s2 > dn_hi_q) dn_hi_d = dn_s2;
				if (clamp_s2 < out_lo_q) out_lo_d = clamp_s2;
				if (clamp_s2 > out_hi_q) out_hi_d = clamp_s2;
			end
			seen_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_cnt_q <= '0;
			valid_cnt_q <= '0;
			seen_q <= 1'b0;
		end else if (adv && v_s2) begin
			fill_cnt_q <= fill_cnt_d;
			valid_cnt_q <= valid_cnt_d;
			seen_q <= seen_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			dn_lo_q <= dn_lo_d;
			dn_hi_q <= dn_hi_d;
			out_lo_q <= out_lo_d;
			out_hi_q <= out_hi_d;
		end
	end

	logic [ShowW-1:0] fill_ext;
	logic [ShowW-1:0] valid_ext;
	logic [31:0]      fill_show;
	logic [31:0]      valid_show;

	assign fill_ext = ShowW'(fill_cnt_d);
	assign valid_ext = ShowW'(valid_cnt_d);
	assign fill_show = (fill_ext > ShowW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : fill_ext[31:0];
	assign valid_show = (valid_ext > ShowW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : valid_ext[31:0];

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			m_tdata[15:0] <= value_s2;
			m_tdata[47:16] <= fill_show;
			m_tdata[79:48] <= valid_show;
			m_tdata[95:80] <= seen_d ? dn_lo_d : 16'd0;
			m_tdata[111:96] <= seen_d ? dn_hi_d : 16'd0;
			m_tdata[127:112] <= seen_d ? out_lo_d : 16'sd0;
			m_tdata[143:128] <= seen_d ? out_hi_d : 16'sd0;
			m_tuser[dtrc_pkg::USER_FILL] <= fill_s2;
			m_tuser[dtrc_pkg::USER_SAT] <= sat_s2;
			m_tuser[dtrc_pkg::USER_STATS] <= seen_d;
		end
	end

endmodule

>>> hdl/dtrc_checker.sv
`include "dn_to_toa_reflectance_calibrator_macros.svh"

module dtrc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [dtrc_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	input logic [dtrc_pkg::OUT_USER_BITS-1:0]  m_tuser
);

	logic fill_flag;
	logic sat_flag;
	logic stats_flag;

	assign fill_flag = m_tuser[dtrc_pkg::USER_FILL];
	assign sat_flag = m_tuser[dtrc_pkg::USER_SAT];
	assign stats_flag = m_tuser[dtrc_pkg::USER_STATS];

	// A pixel is never both fill and saturated.
	`DTRC_ASSERT_NOW(a_one_class, clk, arst_n, m_tvalid, !(fill_flag && sat_flag))

	// Without a converted pixel in the band all extremes read as zero.
	`DTRC_ASSERT_NOW(a_empty_stats, clk, arst_n, m_tvalid && !stats_flag, m_tdata[143:80] == '0)

	// Once statistics exist, the sample and output minimum never exceed the maximum.
	`DTRC_ASSERT_NOW(a_ordered_stats, clk, arst_n, m_tvalid && stats_flag,
		(m_tdata[95:80] <= m_tdata[111:96]) &&
		($signed(m_tdata[127:112]) <= $signed(m_tdata[143:128])))

	// A result that is not taken stays on the output unchanged.
	`DTRC_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind dn_to_toa_reflectance_calibrator dtrc_checker u_dtrc_checker (.*);
